// ----- src/salru_pkg.sv -----
package salru_pkg;

  // default store geometry
  localparam int unsigned MaxSets = 1024;
  localparam int unsigned MaxWays = 8;

  // field widths
  localparam int unsigned TagW  = 62;
  localparam int unsigned AgeW  = 4;
  localparam int unsigned CntW  = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned PaddrW = 4;

  // block size clamp
  localparam logic [3:0] BlockBitsMin = 4'd2;
  localparam logic [3:0] BlockBitsMax = 4'd12;

  // register reset values
  localparam logic [3:0] BlockBitsRst = 4'd6;
  localparam logic [3:0] SetBitsRst   = 4'd10;
  localparam logic [1:0] WayBitsRst   = 2'd3;

  typedef enum logic [1:0] {
    OpRead       = 2'd0,
    OpWrite      = 2'd1,
    OpFlush      = 2'd2,
    OpClearStats = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RegBlockBits = 2'd0,
    RegSetBits   = 2'd1,
    RegWayBits   = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StRead,
    StScan,
    StWrite
  } state_e;

  // one way of a set
  typedef struct packed {
    logic            valid;
    logic [TagW-1:0] tag;
    logic [AgeW-1:0] age;
  } entry_t;

endpackage

// ----- src/salru_ram.sv -----
module salru_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/set_assoc_cache_age_lru.sv -----
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+--------------------------------------
// command   | in        | start, busy               | op_i, address_i
// result    | out       | done_o (one-cycle strobe) | hit_o, way_used_o, reads_o,
//           |           |                           | read_misses_o, writes_o, write_misses_o
// config    | in        | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// A read or write goes from accept to the done_o beat through a set read from the tag RAM,
// a scan of one active way per cycle through the shared tag/age comparator, and a
// write-back. Clear statistics answers in the next cycle. A flush answers
// in the next cycle, then walks all MaxSets rows, one per cycle, while busy stays high.
// After reset and after every register write the same clearing pass over all MaxSets rows runs.
// The receiver cannot stall: each result beat lasts exactly one cycle.
module set_assoc_cache_age_lru #(
  parameter int unsigned MaxSets = salru_pkg::MaxSets,
  parameter int unsigned MaxWays = salru_pkg::MaxWays
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       op_i,
  input  logic [63:0]                      address_i,
  // result
  output logic                             done_o,
  output logic                             hit_o,
  output logic [2:0]                       way_used_o,
  output logic [salru_pkg::CntW-1:0]       reads_o,
  output logic [salru_pkg::CntW-1:0]       read_misses_o,
  output logic [salru_pkg::CntW-1:0]       writes_o,
  output logic [salru_pkg::CntW-1:0]       write_misses_o,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [salru_pkg::PaddrW-1:0]     paddr,
  input  logic [salru_pkg::DataW-1:0]      pwdata,
  output logic [salru_pkg::DataW-1:0]      prdata,
  output logic                             pready
);

  localparam int unsigned SetAw = (MaxSets > 1) ? $clog2(MaxSets) : 1;
  localparam int unsigned WayW  = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned SMax  = $clog2(MaxSets + 1) - 1;
  localparam int unsigned WMax  = $clog2(MaxWays + 1) - 1;
  localparam int unsigned EntW  = $bits(salru_pkg::entry_t);
  localparam int unsigned RowW  = MaxWays * EntW;
  localparam int unsigned CntW  = salru_pkg::CntW;
  localparam int unsigned TagW  = salru_pkg::TagW;
  localparam int unsigned AgeW  = salru_pkg::AgeW;

  salru_pkg::state_e state_q, state_d;

  logic [3:0] block_bits_q;
  logic [3:0] set_bits_q;
  logic [1:0] way_bits_q;

  salru_pkg::op_e   op_q;
  logic [SetAw-1:0] set_q;
  logic [TagW-1:0]  tag_q;
  logic [WayW-1:0]  way_cnt_q;
  logic             hit_fnd_q;
  logic [WayW-1:0]  hit_way_q;
  logic [4:0]       min_age_q;
  logic [WayW-1:0]  min_way_q;
  logic [SetAw-1:0] clr_cnt_q;
  logic             done_q;
  logic             hit_q;
  logic [2:0]       way_q;
  logic [CntW-1:0]  reads_q, read_misses_q, writes_q, write_misses_q;

  logic             cfg_wr, cfg_hit;
  salru_pkg::reg_e  reg_idx;
  logic             accept;
  salru_pkg::op_e   op_in;
  logic [3:0]       bb_eff, sb_eff;
  logic [1:0]       wb_eff;
  logic [4:0]       ways;
  logic [4:0]       shamt;
  logic [63:0]      addr_set_sh, addr_tag_sh;
  logic [SetAw-1:0] set_in;
  logic             scan_last, clr_last;
  logic [WayW-1:0]  victim;

  logic             ram_we, ram_re;
  logic [SetAw-1:0] ram_waddr;
  logic [RowW-1:0]  ram_wdata, ram_rdata;

  salru_pkg::entry_t row_rd  [MaxWays];
  salru_pkg::entry_t row_new [MaxWays];
  salru_pkg::entry_t cur;

  // config handshake
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = salru_pkg::reg_e'(paddr[3:2]);
  always_comb begin
    cfg_hit = 1'b0;
    prdata  = '0;
    case (reg_idx)
      salru_pkg::RegBlockBits: begin
        cfg_hit = cfg_wr;
        prdata  = {28'd0, block_bits_q};
      end
      salru_pkg::RegSetBits: begin
        cfg_hit = cfg_wr;
        prdata  = {28'd0, set_bits_q};
      end
      salru_pkg::RegWayBits: begin
        cfg_hit = cfg_wr;
        prdata  = {30'd0, way_bits_q};
      end
      default: begin
        cfg_hit = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bits_q <= salru_pkg::BlockBitsRst;
      set_bits_q   <= salru_pkg::SetBitsRst;
      way_bits_q   <= salru_pkg::WayBitsRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        salru_pkg::RegBlockBits: block_bits_q <= pwdata[3:0];
        salru_pkg::RegSetBits:   set_bits_q   <= pwdata[3:0];
        salru_pkg::RegWayBits:   way_bits_q   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    if (block_bits_q < salru_pkg::BlockBitsMin) begin
      bb_eff = salru_pkg::BlockBitsMin;
    end else if (block_bits_q > salru_pkg::BlockBitsMax) begin
      bb_eff = salru_pkg::BlockBitsMax;
    end else begin
      bb_eff = block_bits_q;
    end
    sb_eff = (int'(set_bits_q) > SMax) ? 4'(SMax) : set_bits_q;
    wb_eff = (int'(way_bits_q) > WMax) ? 2'(WMax) : way_bits_q;
  end

  assign ways  = 5'd1 << wb_eff;
  assign shamt = {1'b0, bb_eff} + {1'b0, sb_eff};

  // set index and tag from the address
  assign addr_set_sh = address_i >> bb_eff;
  assign addr_tag_sh = address_i >> shamt;
  assign set_in      = addr_set_sh[SetAw-1:0] & ~({SetAw{1'b1}} << sb_eff);

  assign busy   = (state_q != salru_pkg::StIdle);
  assign accept = start & ~busy;
  assign op_in  = salru_pkg::op_e'(op_i);

  // unpack the set row and pick the way under scan
  for (genvar w = 0; w < MaxWays; w++) begin : g_row
    assign row_rd[w] = salru_pkg::entry_t'(ram_rdata[w*EntW +: EntW]);
    assign ram_wdata[w*EntW +: EntW] = row_new[w];
  end
  assign cur       = row_rd[way_cnt_q];
  assign scan_last = (5'(way_cnt_q) == ways - 5'd1);
  assign clr_last  = (clr_cnt_q == SetAw'(MaxSets - 1));
  assign victim    = hit_fnd_q ? hit_way_q : min_way_q;

  // write-back row: age the active ways, refresh the victim
  always_comb begin
    for (int w = 0; w < MaxWays; w++) begin
      row_new[w] = row_rd[w];
      if (5'(w) < ways && row_rd[w].age != '0) begin
        row_new[w].age = row_rd[w].age - AgeW'(1);
      end
      if (WayW'(w) == victim) begin
        row_new[w].age = ways[AgeW-1:0];
        if (!hit_fnd_q) begin
          row_new[w].valid = 1'b1;
          row_new[w].tag   = tag_q;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      salru_pkg::StClear: if (clr_last) state_d = salru_pkg::StIdle;
      salru_pkg::StIdle: begin
        if (accept) begin
          case (op_in)
            salru_pkg::OpRead, salru_pkg::OpWrite: state_d = salru_pkg::StRead;
            salru_pkg::OpFlush:                    state_d = salru_pkg::StClear;
            default:                               state_d = salru_pkg::StIdle;
          endcase
        end
      end
      salru_pkg::StRead:  state_d = salru_pkg::StScan;
      salru_pkg::StScan:  if (scan_last) state_d = salru_pkg::StWrite;
      salru_pkg::StWrite: state_d = salru_pkg::StIdle;
      default:            state_d = salru_pkg::StClear;
    endcase
    if (cfg_hit) begin
      state_d = salru_pkg::StClear;
    end
  end

  // tag RAM controls
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = set_q;
    case (state_q)
      salru_pkg::StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
      end
      salru_pkg::StRead:  ram_re = 1'b1;
      salru_pkg::StWrite: ram_we = 1'b1;
      default: begin
        ram_we = 1'b0;
        ram_re = 1'b0;
      end
    endcase
  end

  salru_ram #(
    .Width (RowW),
    .Depth (MaxSets)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ((state_q == salru_pkg::StClear) ? '0 : ram_wdata),
    .re_i    (ram_re),
    .raddr_i (set_q),
    .rdata_o (ram_rdata)
  );

  // sequencer state and clear sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= salru_pkg::StClear;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_hit || (accept && op_in == salru_pkg::OpFlush)) begin
        clr_cnt_q <= '0;
      end else if (state_q == salru_pkg::StClear) begin
        clr_cnt_q <= clr_cnt_q + SetAw'(1);
      end
    end
  end

  // access datapath: latch, scan with the shared comparator
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_in;
      set_q     <= set_in;
      tag_q     <= addr_tag_sh[TagW-1:0];
      way_cnt_q <= '0;
      hit_fnd_q <= 1'b0;
      hit_way_q <= '0;
      min_age_q <= ways + 5'd1;
      min_way_q <= '0;
    end else if (state_q == salru_pkg::StScan) begin
      way_cnt_q <= way_cnt_q + WayW'(1);
      if (!hit_fnd_q && cur.valid && cur.tag == tag_q) begin
        hit_fnd_q <= 1'b1;
        hit_way_q <= way_cnt_q;
      end
      if ({1'b0, cur.age} < min_age_q) begin
        min_age_q <= {1'b0, cur.age};
        min_way_q <= way_cnt_q;
      end
    end
  end

  // result beat and statistics counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q         <= 1'b0;
      hit_q          <= 1'b0;
      way_q          <= '0;
      reads_q        <= '0;
      read_misses_q  <= '0;
      writes_q       <= '0;
      write_misses_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (accept && (op_in == salru_pkg::OpFlush || op_in == salru_pkg::OpClearStats)) begin
        done_q <= 1'b1;
        hit_q  <= 1'b0;
        way_q  <= '0;
        if (op_in == salru_pkg::OpClearStats) begin
          reads_q        <= '0;
          read_misses_q  <= '0;
          writes_q       <= '0;
          write_misses_q <= '0;
        end
      end else if (state_q == salru_pkg::StWrite) begin
        done_q <= 1'b1;
        hit_q  <= hit_fnd_q;
        way_q  <= 3'(victim);
        if (op_q == salru_pkg::OpRead) begin
          if (reads_q != '1) reads_q <= reads_q + CntW'(1);
          if (!hit_fnd_q && read_misses_q != '1) begin
            read_misses_q <= read_misses_q + CntW'(1);
          end
        end else begin
          if (writes_q != '1) writes_q <= writes_q + CntW'(1);
          if (!hit_fnd_q && write_misses_q != '1) begin
            write_misses_q <= write_misses_q + CntW'(1);
          end
        end
      end
    end
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign way_used_o     = way_q;
  assign reads_o        = reads_q;
  assign read_misses_o  = read_misses_q;
  assign writes_o       = writes_q;
  assign write_misses_o = write_misses_q;

endmodule

// ----- verif/tb_set_assoc_cache_age_lru.sv -----
module tb_set_assoc_cache_age_lru;
  timeunit 1ns;
  timeprecision 1ps;

  import salru_pkg::*;

  // one result beat as predicted
  typedef struct packed {
    logic            hit;
    logic [2:0]      way;
    logic [CntW-1:0] reads;
    logic [CntW-1:0] read_misses;
    logic [CntW-1:0] writes;
    logic [CntW-1:0] write_misses;
  } lookup_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        op_i;
  logic [63:0]       address_i;
  logic              done_o;
  logic              hit_o;
  logic [2:0]        way_used_o;
  logic [CntW-1:0]   reads_o;
  logic [CntW-1:0]   read_misses_o;
  logic [CntW-1:0]   writes_o;
  logic [CntW-1:0]   write_misses_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  set_assoc_cache_age_lru DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .address_i      (address_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .way_used_o     (way_used_o),
    .reads_o        (reads_o),
    .read_misses_o  (read_misses_o),
    .writes_o       (writes_o),
    .write_misses_o (write_misses_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // predicted tag store and counters
  logic [TagW-1:0] tag_mem [MaxSets*MaxWays];
  bit              valid_mem [MaxSets*MaxWays];
  logic [AgeW-1:0] age_mem [MaxSets*MaxWays];
  logic [CntW-1:0] read_cnt, read_miss_cnt, write_cnt, write_miss_cnt;

  // register copies and the geometry they give
  logic [3:0]  block_bits_q;
  logic [3:0]  set_bits_q;
  logic [1:0]  way_bits_q;
  int unsigned eff_bb, eff_sb, eff_ways;

  lookup_t     lookup_q [$];
  int unsigned error_cnt;
  bit          no_gaps;

  // address pools for the current geometry
  logic [63:0] tag_pool [16];
  int unsigned tag_pool_n;
  int unsigned set_pool [4];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("set_assoc_cache_age_lru verification failed");
    $finish;
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      error_cnt++;
    end
  endfunction

  function automatic void clear_tags();
    foreach (valid_mem[i]) begin
      valid_mem[i] = 1'b0;
      tag_mem[i]   = '0;
      age_mem[i]   = '0;
    end
  endfunction

  // clamp the registers to the supported geometry
  function automatic void apply_geometry();
    eff_bb = 32'(block_bits_q);
    if (eff_bb < BlockBitsMin) eff_bb = BlockBitsMin;
    if (eff_bb > BlockBitsMax) eff_bb = BlockBitsMax;
    eff_sb = 32'(set_bits_q);
    if (eff_sb > $clog2(MaxSets)) eff_sb = $clog2(MaxSets);
    eff_ways = 1 << way_bits_q;
    if (eff_ways > MaxWays) eff_ways = MaxWays;
  endfunction

  function automatic lookup_t access_tag_store(op_e op, logic [63:0] addr);
    lookup_t         res;
    int unsigned     set_idx, base, min_age;
    logic [TagW-1:0] tag;
    res = '0;
    case (op)
      OpFlush: begin
        clear_tags();
      end
      OpClearStats: begin
        read_cnt       = '0;
        read_miss_cnt  = '0;
        write_cnt      = '0;
        write_miss_cnt = '0;
      end
      default: begin
        set_idx = 32'((addr >> eff_bb) & ((64'd1 << eff_sb) - 64'd1));
        tag     = TagW'(addr >> (eff_bb + eff_sb));
        base    = set_idx * MaxWays;
        // first valid way with a matching tag
        for (int i = 0; i < eff_ways; i++) begin
          if (!res.hit && valid_mem[base+i] && tag_mem[base+i] == tag) begin
            res.hit = 1'b1;
            res.way = 3'(i);
          end
        end
        // miss: lowest-numbered way with the smallest age is refilled
        if (!res.hit) begin
          min_age = eff_ways + 1;
          for (int i = 0; i < eff_ways; i++) begin
            if (32'(age_mem[base+i]) < min_age) begin
              min_age = 32'(age_mem[base+i]);
              res.way = 3'(i);
            end
          end
          valid_mem[base+res.way] = 1'b1;
          tag_mem[base+res.way]   = tag;
        end
        // age the set, then make the used way the youngest
        for (int i = 0; i < eff_ways; i++) begin
          if (age_mem[base+i] != 0) age_mem[base+i]--;
        end
        age_mem[base+res.way] = AgeW'(eff_ways);
        // saturating counters
        if (op == OpRead) begin
          if (read_cnt != '1) read_cnt++;
          if (!res.hit && read_miss_cnt != '1) read_miss_cnt++;
        end else begin
          if (write_cnt != '1) write_cnt++;
          if (!res.hit && write_miss_cnt != '1) write_miss_cnt++;
        end
      end
    endcase
    res.reads        = read_cnt;
    res.read_misses  = read_miss_cnt;
    res.writes       = write_cnt;
    res.write_misses = write_miss_cnt;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic op_e pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 47) return OpRead;
    if (r < 94) return OpWrite;
    if (r < 97) return OpFlush;
    return OpClearStats;
  endfunction

  function automatic void refill_pools();
    tag_pool_n = eff_ways + $urandom_range(0, 3);
    foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
    foreach (set_pool[i]) set_pool[i] = $urandom & ((1 << eff_sb) - 1);
  endfunction

  // mostly a small working set of tags over a few sets, sometimes any address
  function automatic logic [63:0] make_addr();
    logic [63:0] a;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    a = tag_pool[$urandom_range(0, tag_pool_n - 1)] << (eff_bb + eff_sb);
    a |= 64'(set_pool[$urandom_range(0, 3)]) << eff_bb;
    a |= 64'($urandom) & ((64'd1 << eff_bb) - 64'd1);
    return a;
  endfunction

  // one command beat, then a random gap
  task automatic send_beat(op_e op, logic [63:0] addr);
    int unsigned gap;
    @(negedge clk_i);
    start     <= 1'b1;
    op_i      <= op;
    address_i <= addr;
    do @(posedge clk_i); while (busy);
    lookup_q.push_back(access_tag_store(op, addr));
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // stop issuing and let every outstanding beat and any clearing walk finish
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (lookup_q.size() != 0 || busy) @(negedge clk_i);
  endtask

  // apb write, then read back and compare
  task automatic write_reg(reg_e idx, logic [DataW-1:0] value);
    logic [DataW-1:0] mask;
    mask = (idx == RegWayBits) ? 32'h3 : 32'hF;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~mask) | (value & mask);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegBlockBits: block_bits_q = value[3:0];
      RegSetBits:   set_bits_q   = value[3:0];
      default:      way_bits_q   = value[1:0];
    endcase
    apply_geometry();
    clear_tags();
    // read back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", 64'(value & mask), 64'(prdata & mask));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_geometry(logic [3:0] bb, logic [3:0] sb, logic [1:0] wb);
    wait_drained();
    write_reg(RegBlockBits, 32'(bb));
    write_reg(RegSetBits, 32'(sb));
    write_reg(RegWayBits, 32'(wb));
    refill_pools();
  endtask

  // hit and miss on the reset geometry, address extremes
  task automatic test_basic_hits();
    send_beat(OpRead, 64'h0);
    send_beat(OpRead, 64'h3F);
    send_beat(OpWrite, 64'h0);
    send_beat(OpWrite, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(OpRead, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(OpRead, 64'h8000_0000_0000_0000);
  endtask

  // fill one set, refresh a way, then force an eviction
  task automatic test_lru_eviction();
    for (int t = 1; t <= 8; t++) send_beat(OpRead, (64'(t) << 16) | (64'd5 << 6));
    send_beat(OpWrite, (64'd1 << 16) | (64'd5 << 6));
    send_beat(OpRead, (64'd9 << 16) | (64'd5 << 6));
    send_beat(OpRead, (64'd2 << 16) | (64'd5 << 6));
  endtask

  task automatic test_flush_and_stats();
    send_beat(OpFlush, {$urandom, $urandom});
    send_beat(OpRead, 64'h0);
    send_beat(OpClearStats, {$urandom, $urandom});
    send_beat(OpWrite, 64'h0);
  endtask

  // out-of-range and extreme register values, each with a burst of traffic
  task automatic test_register_sweep();
    logic [3:0] bb_list [6] = '{4'd0, 4'd15, 4'd1, 4'd13, 4'd2, 4'd12};
    logic [3:0] sb_list [6] = '{4'd0, 4'd15, 4'd11, 4'd10, 4'd1, 4'd3};
    logic [1:0] wb_list [6] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3};
    for (int k = 0; k < 6; k++) begin
      set_geometry(bb_list[k], sb_list[k], wb_list[k]);
      repeat (25) send_beat(pick_op(), make_addr());
    end
  endtask

  // phases of random geometry and traffic
  task automatic test_random_traffic();
    logic [3:0] sb;
    for (int ph = 0; ph < 10; ph++) begin
      sb = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(0, 15));
      set_geometry(4'($urandom_range(0, 15)), sb, 2'($urandom_range(0, 3)));
      no_gaps = (ph == 3);
      for (int n = 0; n < 160; n++) begin
        if (ph == 5 && n == 80) wait_drained();
        send_beat(pick_op(), make_addr());
      end
    end
    no_gaps = 1'b0;
  endtask

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni && done_o) begin
      if (lookup_q.size() == 0) begin
        $error("result beat with no access outstanding");
        error_cnt++;
      end else begin
        want = lookup_q.pop_front();
        check_field("hit", 64'(want.hit), 64'(hit_o));
        check_field("way_used", 64'(want.way), 64'(way_used_o));
        check_field("reads", 64'(want.reads), 64'(reads_o));
        check_field("read_misses", 64'(want.read_misses), 64'(read_misses_o));
        check_field("writes", 64'(want.writes), 64'(writes_o));
        check_field("write_misses", 64'(want.write_misses), 64'(write_misses_o));
      end
    end
  end

  initial begin
    error_cnt      = 0;
    no_gaps        = 1'b0;
    start          = 1'b0;
    op_i           = OpRead;
    address_i      = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    read_cnt       = '0;
    read_miss_cnt  = '0;
    write_cnt      = '0;
    write_miss_cnt = '0;
    block_bits_q   = BlockBitsRst;
    set_bits_q     = SetBitsRst;
    way_bits_q     = WayBitsRst;
    apply_geometry();
    clear_tags();
    refill_pools();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_hits();
    test_lru_eviction();
    test_flush_and_stats();
    test_register_sweep();
    test_random_traffic();

    wait_drained();
    repeat (MaxWays + 8) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("set_assoc_cache_age_lru verification clean");
    end else begin
      $display("set_assoc_cache_age_lru verification failed");
    end
    $finish;
  end

endmodule
